// ===== design/tlvhp_pkg.sv =====
// ----------------------------------------------------------------------------
// tlvhp_pkg
// types and constants shared by the tlv header parser
// ----------------------------------------------------------------------------
package tlvhp_pkg;

   localparam logic [7:0] TagMultiMask = 8'h1F;
   localparam logic [7:0] LongFormBit  = 8'h80;
   localparam logic [7:0] ShortMask    = 8'h7F;
   localparam logic [7:0] LenOneByte   = 8'h81;
   localparam logic [7:0] LenTwoByte   = 8'h82;

   typedef enum logic [4:0] {
      PH_IDLE = 5'b00001,
      PH_TAG2 = 5'b00010,
      PH_TAG3 = 5'b00100,
      PH_LEN  = 5'b01000,
      PH_LENX = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_flag;
   } req_type;

   typedef struct packed {
      logic [23:0] tag_word;
      logic [1:0]  tag_size;
      logic [15:0] length_word;
      logic [2:0]  header_size;
      logic        bad_length;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type rsp;
   } step_out_type;

endpackage

// ===== design/tlvhp_if.sv =====
// ----------------------------------------------------------------------------
// tlvhp_if
// valid/ready channels for header bytes and decoded headers
// ----------------------------------------------------------------------------
interface tlvhp_req_chan_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_flag;

   modport source (output valid, output data_byte, output start_flag, input ready);
   modport sink   (input valid, input data_byte, input start_flag, output ready);
endinterface

interface tlvhp_rsp_chan_if;
   logic        valid;
   logic        ready;
   logic [23:0] tag_word;
   logic [1:0]  tag_size;
   logic [15:0] length_word;
   logic [2:0]  header_size;
   logic        bad_length;

   modport source (output valid, output tag_word, output tag_size, output length_word,
                   output header_size, output bad_length, input ready);
   modport sink   (input valid, input tag_word, input tag_size, input length_word,
                   input header_size, input bad_length, output ready);
endinterface

// ===== design/tlv_header_parser.sv =====
// ----------------------------------------------------------------------------
// tlv_header_parser
// BER-TLV header parser, one header byte per transaction
// ----------------------------------------------------------------------------
// Takes one header byte per clock cycle when the result register is free or
// being drained in the same cycle. Tag bytes, the length form byte and any
// long-form length bytes each take one transaction; the decoded header
// appears in the result register in the cycle after its last byte is accepted.
// A start flag drops any partial header. A bad length form gives a result
// with bad_length set and header_size zero.
module tlv_header_parser (
   input logic                clock,
   input logic                reset,
   tlvhp_req_chan_if.sink     req_bus,
   tlvhp_rsp_chan_if.source   rsp_bus
);
   import tlvhp_pkg::*;

   logic         accept;
   logic         req_ready;
   req_type      req;
   step_out_type result;
   rsp_type      rsp_data;

   assign req.data_byte  = req_bus.data_byte;
   assign req.start_flag = req_bus.start_flag;
   assign req_bus.ready  = req_ready;
   assign accept         = req_bus.valid && req_ready;

   tlvhp_step u_step (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req),
      .result (result)
   );

   tlvhp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .result    (result),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_data  (rsp_data),
      .req_ready (req_ready)
   );

   assign rsp_bus.tag_word    = rsp_data.tag_word;
   assign rsp_bus.tag_size    = rsp_data.tag_size;
   assign rsp_bus.length_word = rsp_data.length_word;
   assign rsp_bus.header_size = rsp_data.header_size;
   assign rsp_bus.bad_length  = rsp_data.bad_length;

endmodule

// ===== design/tlvhp_step.sv =====
// ----------------------------------------------------------------------------
// tlvhp_step
// parser state and per-byte decode, one byte per accepted transaction
// ----------------------------------------------------------------------------
module tlvhp_step (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  tlvhp_pkg::req_type    req,
   output tlvhp_pkg::step_out_type result
);
   import tlvhp_pkg::*;

   phase_type   phase_ff, phase_in, phase_cur;
   logic [23:0] tag_acc_ff, tag_acc_in;
   logic [1:0]  tag_count_ff, tag_count_in;
   logic [15:0] length_acc_ff, length_acc_in;
   logic [1:0]  length_left_ff, length_left_in;
   logic [2:0]  byte_count_ff, byte_count_in;
   logic [7:0]  b;
   logic [2:0]  count_inc;
   logic [1:0]  left_dec;
   logic [15:0] length_shift;

   assign b            = req.data_byte;
   assign count_inc    = byte_count_ff + 3'd1;
   assign left_dec     = length_left_ff - 2'd1;
   assign length_shift = {length_acc_ff[7:0], b};
   assign phase_cur    = req.start_flag ? PH_IDLE : phase_ff;

   always_comb begin
      phase_in       = phase_ff;
      tag_acc_in     = tag_acc_ff;
      tag_count_in   = tag_count_ff;
      length_acc_in  = length_acc_ff;
      length_left_in = length_left_ff;
      byte_count_in  = byte_count_ff;
      result.valid   = 1'b0;
      result.rsp.tag_word    = tag_acc_ff;
      result.rsp.tag_size    = tag_count_ff;
      result.rsp.length_word = 16'd0;
      result.rsp.header_size = 3'd0;
      result.rsp.bad_length  = 1'b0;
      unique case (phase_cur)
         PH_TAG2: begin
            tag_acc_in    = {tag_acc_ff[15:0], b};
            tag_count_in  = 2'd2;
            byte_count_in = 3'd2;
            phase_in      = ((b & LongFormBit) != 8'd0) ? PH_TAG3 : PH_LEN;
         end
         PH_TAG3: begin
            tag_acc_in    = {tag_acc_ff[15:0], b};
            tag_count_in  = 2'd3;
            byte_count_in = 3'd3;
            phase_in      = PH_LEN;
         end
         PH_LEN: begin
            byte_count_in = count_inc;
            if ((b & LongFormBit) == 8'd0) begin
               result.valid           = 1'b1;
               result.rsp.length_word = {8'd0, b & ShortMask};
               result.rsp.header_size = count_inc;
               phase_in               = PH_IDLE;
            end else if (b == LenOneByte || b == LenTwoByte) begin
               length_left_in = b[1:0];
               length_acc_in  = 16'd0;
               phase_in       = PH_LENX;
            end else begin
               result.valid          = 1'b1;
               result.rsp.bad_length = 1'b1;
               phase_in              = PH_IDLE;
            end
         end
         PH_LENX: begin
            length_acc_in  = length_shift;
            byte_count_in  = count_inc;
            length_left_in = left_dec;
            if (left_dec == 2'd0) begin
               result.valid           = 1'b1;
               result.rsp.length_word = length_shift;
               result.rsp.header_size = count_inc;
               phase_in               = PH_IDLE;
            end
         end
         default: begin
            tag_acc_in     = {16'd0, b};
            tag_count_in   = 2'd1;
            length_acc_in  = 16'd0;
            length_left_in = 2'd0;
            byte_count_in  = 3'd1;
            phase_in       = ((b & TagMultiMask) == TagMultiMask) ? PH_TAG2 : PH_LEN;
         end
      endcase
      if (!accept) begin
         result.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         tag_acc_ff     <= '0;
         tag_count_ff   <= '0;
         length_acc_ff  <= '0;
         length_left_ff <= '0;
         byte_count_ff  <= '0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         tag_acc_ff     <= tag_acc_in;
         tag_count_ff   <= tag_count_in;
         length_acc_ff  <= length_acc_in;
         length_left_ff <= length_left_in;
         byte_count_ff  <= byte_count_in;
      end
   end

endmodule

// ===== design/tlvhp_out_reg.sv =====
// ----------------------------------------------------------------------------
// tlvhp_out_reg
// result register holding one decoded header until the sink takes it
// ----------------------------------------------------------------------------
module tlvhp_out_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  tlvhp_pkg::step_out_type result,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output tlvhp_pkg::rsp_type     rsp_data,
   output logic                   req_ready
);
   import tlvhp_pkg::*;

   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;

   assign req_ready    = !out_valid_ff || rsp_ready;
   assign out_valid_in = accept ? result.valid : (out_valid_ff && !rsp_ready);
   assign rsp_valid    = out_valid_ff;
   assign rsp_data     = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && result.valid) begin
         out_data_ff <= result.rsp;
      end
   end

endmodule
